// File: src/hpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Widths, register reset values and pipeline depth for the homogeneous
// point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int CW      = 32;            // coefficient / coordinate width
    localparam int PW      = 64;            // product width
    localparam int SW      = 66;            // row sum width
    localparam int MW      = 65;            // row sum magnitude width
    localparam int FRAC    = 16;            // fraction bits of Q16.16
    localparam int NW      = MW + FRAC;     // dividend width
    localparam int QW      = 34;            // quotient bits, two above the result
    localparam int XW      = MW + QW - 1;   // width of the shifted divisor
    localparam int NROW    = 4;
    localparam int NLANE   = 3;
    localparam int NREG    = 8;
    localparam int RW      = 64;            // configuration register width
    localparam int AW      = 6;             // byte address, 8 bytes per register
    localparam int LATENCY = QW + 4;        // accept edge to result edge

    localparam logic [RW-1:0] CFG_RESET [NREG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    localparam logic [CW-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] NEG_MIN = 32'h8000_0000;

    typedef logic signed [CW-1:0] t_coef;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;

endpackage

// File: src/homogeneous_point_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// Multiplies (x, y, z, 1) by a 4x4 Q16.16 matrix and divides x, y, z by w.
// ----------------------------------------------------------------------------
// Usage:
//   Matrix: eight 64-bit registers on the APB port, register i at byte
//   address 8*i, two Q16.16 coefficients each, low half first. pready is
//   always high. Write only while no transfer is in flight.
//   Input: a transfer is taken at a rising edge with start high and busy
//   low. busy is never raised: a point can enter in every cycle.
//   Output: each point gives one result, shown for one cycle with o_valid
//   high. Throughput is one point per cycle. The depth is set by the
//   multiply, row sum and sign/magnitude stages, the 34-stage restoring
//   divider (one quotient bit per stage) and the output stage.
//   w zero or negative: o_bad_w is high and the coordinates are zero.
//   Quotients beyond the Q16.16 range saturate.
//   The receiver cannot stall; results are never held back.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpt_pkg::AW-1:0]      paddr,
    input  logic [hpt_pkg::RW-1:0]      pwdata,
    output logic [hpt_pkg::RW-1:0]      prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          i_point_x,
    input  logic signed [31:0]          i_point_y,
    input  logic signed [31:0]          i_point_z,
    output logic                        o_valid,
    output logic signed [31:0]          o_out_x,
    output logic signed [31:0]          o_out_y,
    output logic signed [31:0]          o_out_z,
    output logic                        o_bad_w
);

    localparam int QW = hpt_pkg::QW;
    localparam int NW = hpt_pkg::NW;
    localparam int MW = hpt_pkg::MW;
    localparam int XW = hpt_pkg::XW;
    localparam int SW = hpt_pkg::SW;
    localparam int PW = hpt_pkg::PW;
    localparam int CW = hpt_pkg::CW;

    // configuration registers
    logic [hpt_pkg::RW-1:0] r_cfg [hpt_pkg::NREG];
    logic [2:0]             cfg_idx;
    logic                   cfg_wr;

    assign cfg_idx = paddr[hpt_pkg::AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = r_cfg[cfg_idx];
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::NREG; i++) begin
                r_cfg[i] <= hpt_pkg::CFG_RESET[i];
            end
        end else if (cfg_wr) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    // matrix view of the registers
    hpt_pkg::t_coef m [hpt_pkg::NROW][hpt_pkg::NROW];
    hpt_pkg::t_coef p [hpt_pkg::NLANE];

    always_comb begin
        for (int r = 0; r < hpt_pkg::NROW; r++) begin
            for (int c = 0; c < hpt_pkg::NROW; c++) begin
                if (c % 2 == 1) begin
                    m[r][c] = r_cfg[2 * r + c / 2][2*CW-1:CW];
                end else begin
                    m[r][c] = r_cfg[2 * r + c / 2][CW-1:0];
                end
            end
        end
    end

    assign p[0] = i_point_x;
    assign p[1] = i_point_y;
    assign p[2] = i_point_z;

    // stage 1: products, stage 2: row sums
    logic           r_mul_v;
    logic           r_sum_v;
    hpt_pkg::t_prod r_prod [hpt_pkg::NROW][hpt_pkg::NLANE];
    hpt_pkg::t_sum  r_row  [hpt_pkg::NROW];

    // stage 3 onward: sign/magnitude, then one quotient bit per stage
    logic             r_dv_v   [QW+1];
    logic             r_dv_bad [QW+1];
    logic [MW-1:0]    r_dv_w   [QW+1];
    logic             r_dv_neg [QW+1][hpt_pkg::NLANE];
    logic [NW-1:0]    r_dv_rem [QW+1][hpt_pkg::NLANE];
    logic [QW-1:0]    r_dv_q   [QW+1][hpt_pkg::NLANE];

    logic [NW-1:0]    n_rem [QW][hpt_pkg::NLANE];
    logic [QW-1:0]    n_q   [QW][hpt_pkg::NLANE];

    // prep
    logic             w_bad;
    logic [MW-1:0]    w_div;
    logic             n_neg [hpt_pkg::NLANE];
    logic [NW-1:0]    n_num [hpt_pkg::NLANE];

    always_comb begin
        hpt_pkg::t_sum mag;
        w_bad = r_row[3][SW-1] || (r_row[3] == '0);
        w_div = w_bad ? MW'(1) : r_row[3][MW-1:0];
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            n_neg[l] = r_row[l][SW-1];
            mag      = n_neg[l] ? -r_row[l] : r_row[l];
            n_num[l] = {mag[MW-1:0], {hpt_pkg::FRAC{1'b0}}};
        end
    end

    // restoring divide steps
    always_comb begin
        logic [XW-1:0] dsh;
        logic [XW-1:0] remx;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < hpt_pkg::NLANE; l++) begin
                dsh  = XW'(r_dv_w[k]) << (QW - 1 - k);
                remx = XW'(r_dv_rem[k][l]);
                if (remx >= dsh) begin
                    n_rem[k][l] = NW'(remx - dsh);
                    n_q[k][l]   = r_dv_q[k][l] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_rem[k][l] = r_dv_rem[k][l];
                    n_q[k][l]   = r_dv_q[k][l];
                end
            end
        end
    end

    function automatic logic [CW-1:0] sat_q(input logic neg, input logic [QW-1:0] q);
        if (!neg) begin
            return (q > QW'(hpt_pkg::POS_MAX)) ? hpt_pkg::POS_MAX : q[CW-1:0];
        end
        return (q > QW'(hpt_pkg::NEG_MIN)) ? hpt_pkg::NEG_MIN : CW'(0) - q[CW-1:0];
    endfunction

    // output stage
    logic          r_out_v;
    logic [CW-1:0] r_out_c [hpt_pkg::NLANE];
    logic          r_out_bad;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_sum_v <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else begin
            r_mul_v   <= start && !busy;
            r_sum_v   <= r_mul_v;
            r_dv_v[0] <= r_sum_v;
            for (int k = 0; k < QW; k++) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_out_v <= r_dv_v[QW];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < hpt_pkg::NROW; r++) begin
            for (int c = 0; c < hpt_pkg::NLANE; c++) begin
                r_prod[r][c] <= PW'(m[r][c]) * PW'(p[c]);
            end
            r_row[r] <= SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + SW'(r_prod[r][2])
                        + (SW'(m[r][3]) <<< hpt_pkg::FRAC);
        end

        r_dv_bad[0] <= w_bad;
        r_dv_w[0]   <= w_div;
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            r_dv_neg[0][l] <= n_neg[l];
            r_dv_rem[0][l] <= n_num[l];
            r_dv_q[0][l]   <= '0;
        end

        for (int k = 0; k < QW; k++) begin
            r_dv_bad[k+1] <= r_dv_bad[k];
            r_dv_w[k+1]   <= r_dv_w[k];
            for (int l = 0; l < hpt_pkg::NLANE; l++) begin
                r_dv_neg[k+1][l] <= r_dv_neg[k][l];
                r_dv_rem[k+1][l] <= n_rem[k][l];
                r_dv_q[k+1][l]   <= n_q[k][l];
            end
        end

        r_out_bad <= r_dv_bad[QW];
        for (int l = 0; l < hpt_pkg::NLANE; l++) begin
            r_out_c[l] <= r_dv_bad[QW] ? '0 : sat_q(r_dv_neg[QW][l], r_dv_q[QW][l]);
        end
    end

    assign o_valid = r_out_v;
    assign o_out_x = r_out_c[0];
    assign o_out_y = r_out_c[1];
    assign o_out_z = r_out_c[2];
    assign o_bad_w = r_out_bad;

    // checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(hpt_pkg::LATENCY) o_valid)
        else $error("accepted point produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, hpt_pkg::LATENCY))
        else $error("result without an accepted point");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_w) |-> (o_out_x == 0 && o_out_y == 0 && o_out_z == 0))
        else $error("bad w result with nonzero coordinates");

endmodule
